// ===== rtl/bpc_pkg.sv =====
// Shared types and constants for the barometric compensation block.
package bpc_pkg;

    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int STAGES  = 6;

    typedef logic        [23:0] t_raw;
    typedef logic        [15:0] t_coef;
    typedef logic signed [18:0] t_temp;
    typedef logic signed [22:0] t_press;
    typedef logic        [2:0]  t_reg_idx;

    localparam t_reg_idx REG_C1 = 3'd0;
    localparam t_reg_idx REG_C2 = 3'd1;
    localparam t_reg_idx REG_C3 = 3'd2;
    localparam t_reg_idx REG_C4 = 3'd3;
    localparam t_reg_idx REG_C5 = 3'd4;
    localparam t_reg_idx REG_C6 = 3'd5;

    localparam t_temp TEMP_BASE = 19'sd2000;

endpackage

// ===== rtl/bpc_in_if.sv =====
// Raw sample channel: pressure and temperature conversions.
interface bpc_in_if;
    import bpc_pkg::*;

    logic valid;
    logic ready;
    t_raw pressure_raw;
    t_raw temperature_raw;

    modport source (output valid, output pressure_raw, output temperature_raw, input ready);
    modport sink   (input valid, input pressure_raw, input temperature_raw, output ready);
endinterface

// ===== rtl/bpc_out_if.sv =====
// Compensated result channel: temperature and pressure.
interface bpc_out_if;
    import bpc_pkg::*;

    logic   valid;
    logic   ready;
    t_temp  temperature_centideg;
    t_press pressure_centimbar;

    modport source (output valid, output temperature_centideg, output pressure_centimbar,
                    input ready);
    modport sink   (input valid, input temperature_centideg, input pressure_centimbar,
                    output ready);
endinterface

// ===== rtl/baro_pressure_temp_compensation_top.sv =====
// Top level: six-stage first-order pressure and temperature compensation pipeline.
// Throughput: one sample pair per cycle while o_result.ready allows; each stage holds when the one
// after it is full and stalled, so a stage frees up as soon as its contents move on.
// The 60-bit pressure product is split into two partial products and summed a stage later.
// Reset (synchronous, active low) clears stage valid bits and sets all coefficients to 0.
module baro_pressure_temp_compensation_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [bpc_pkg::ADDR_W-1:0] paddr,
    input  logic [bpc_pkg::DATA_W-1:0] pwdata,
    output logic [bpc_pkg::DATA_W-1:0] prdata,
    output logic                  pready,
    bpc_in_if.sink                i_sample,
    bpc_out_if.source             o_result
);
    import bpc_pkg::*;

    // calibration registers
    t_coef r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;
    t_reg_idx reg_idx;

    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
            r_c5 <= '0;
            r_c6 <= '0;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_C1:  r_c1 <= pwdata[15:0];
                REG_C2:  r_c2 <= pwdata[15:0];
                REG_C3:  r_c3 <= pwdata[15:0];
                REG_C4:  r_c4 <= pwdata[15:0];
                REG_C5:  r_c5 <= pwdata[15:0];
                REG_C6:  r_c6 <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_C1:  prdata = {16'h0, r_c1};
            REG_C2:  prdata = {16'h0, r_c2};
            REG_C3:  prdata = {16'h0, r_c3};
            REG_C4:  prdata = {16'h0, r_c4};
            REG_C5:  prdata = {16'h0, r_c5};
            REG_C6:  prdata = {16'h0, r_c6};
            default: prdata = '0;
        endcase
    end

    // pipeline flow control
    logic [STAGES-1:0] r_v;
    logic [STAGES-1:0] en;

    always_comb begin
        en[STAGES-1] = !r_v[STAGES-1] || o_result.ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign i_sample.ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_sample.valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 0: dT = D2 - C5*2^8
    t_raw               r_s0_d1;
    logic signed [24:0] r_s0_dt;
    logic signed [24:0] n_s0_dt;

    assign n_s0_dt = $signed({1'b0, i_sample.temperature_raw}) - $signed({1'b0, r_c5, 8'h00});

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s0_d1 <= i_sample.pressure_raw;
            r_s0_dt <= n_s0_dt;
        end
    end

    // stage 1: dT products
    t_raw               r_s1_d1;
    logic signed [41:0] r_s1_t6, r_s1_t4, r_s1_t3;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_s1_d1 <= r_s0_d1;
            r_s1_t6 <= r_s0_dt * $signed({1'b0, r_c6});
            r_s1_t4 <= r_s0_dt * $signed({1'b0, r_c4});
            r_s1_t3 <= r_s0_dt * $signed({1'b0, r_c3});
        end
    end

    // stage 2: TEMP, OFF, SENS
    logic signed [41:0] t6_sh, t4_sh, t3_sh;
    t_temp              n_s2_temp;
    logic signed [35:0] n_s2_off;
    logic signed [34:0] n_s2_sens;
    t_raw               r_s2_d1;
    t_temp              r_s2_temp;
    logic signed [35:0] r_s2_off;
    logic signed [34:0] r_s2_sens;

    assign t6_sh     = r_s1_t6 >>> 23;
    assign t4_sh     = r_s1_t4 >>> 7;
    assign t3_sh     = r_s1_t3 >>> 8;
    assign n_s2_temp = TEMP_BASE + $signed(t6_sh[18:0]);
    assign n_s2_off  = $signed({4'h0, r_c2, 16'h0000}) + $signed(t4_sh[35:0]);
    assign n_s2_sens = $signed({4'h0, r_c1, 15'h0000}) + $signed(t3_sh[34:0]);

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_s2_d1   <= r_s1_d1;
            r_s2_temp <= n_s2_temp;
            r_s2_off  <= n_s2_off;
            r_s2_sens <= n_s2_sens;
        end
    end

    // stage 3: D1*SENS as two partial products
    t_temp              r_s3_temp;
    logic signed [35:0] r_s3_off;
    logic        [40:0] r_s3_p_lo;
    logic signed [42:0] r_s3_p_hi;
    logic signed [17:0] sens_hi;

    assign sens_hi = r_s2_sens[34:17];

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_s3_temp <= r_s2_temp;
            r_s3_off  <= r_s2_off;
            r_s3_p_lo <= r_s2_d1 * r_s2_sens[16:0];
            r_s3_p_hi <= $signed({1'b0, r_s2_d1}) * sens_hi;
        end
    end

    // stage 4: combine partial products, floor by 2^21
    logic signed [59:0] prod;
    logic signed [59:0] prod_sh;
    t_temp              r_s4_temp;
    logic signed [35:0] r_s4_off;
    logic signed [38:0] r_s4_q;

    assign prod    = $signed({r_s3_p_hi[42:0], 17'h00000}) + $signed({19'h00000, r_s3_p_lo});
    assign prod_sh = prod >>> 21;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_s4_temp <= r_s3_temp;
            r_s4_off  <= r_s3_off;
            r_s4_q    <= prod_sh[38:0];
        end
    end

    // stage 5: P = (q - OFF) / 2^15, output register
    logic signed [39:0] diff;
    logic signed [39:0] diff_sh;
    t_temp              r_s5_temp;
    t_press             r_s5_press;

    assign diff    = $signed({r_s4_q[38], r_s4_q}) - $signed({{4{r_s4_off[35]}}, r_s4_off});
    assign diff_sh = diff >>> 15;

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_s5_temp  <= r_s4_temp;
            r_s5_press <= diff_sh[22:0];
        end
    end

    assign o_result.valid                = r_v[STAGES-1];
    assign o_result.temperature_centideg = r_s5_temp;
    assign o_result.pressure_centimbar   = r_s5_press;

endmodule
